// ===== sv/bec_pkg.sv =====
// bec_pkg: constants, result types and byte/code tables for the byte escape codec.
// No dependencies; imported by bec_map, bec_outq, byte_escape_codec and tb.
`timescale 1ns / 1ps

package bec_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic [7:0] ESC_LEAD = 8'd254;
    localparam logic [7:0] ZERO_SUB = 8'd255;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic [2:0] code_of(input logic [7:0] b);
        logic [2:0] c;
        case (b)
            8'd10:   c = 3'd1;
            8'd13:   c = 3'd2;
            8'd34:   c = 3'd3;
            8'd39:   c = 3'd4;
            8'd92:   c = 3'd5;
            8'd254:  c = 3'd6;
            8'd255:  c = 3'd7;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] special_of(input logic [2:0] c);
        logic [7:0] b;
        case (c)
            3'd1:    b = 8'd10;
            3'd2:    b = 8'd13;
            3'd3:    b = 8'd34;
            3'd4:    b = 8'd39;
            3'd5:    b = 8'd92;
            3'd6:    b = 8'd254;
            3'd7:    b = 8'd255;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/bec_map.sv =====
// bec_map: mode register, decode state bits and the per-byte mapping to up to two results.
// Depends on bec_pkg.
`timescale 1ns / 1ps

module bec_map (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_mode,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output bec_pkg::t_push o_push
);
    import bec_pkg::*;

    logic  r_mode;
    logic  r_esc, n_esc;
    logic  r_end, n_end;
    t_push push;
    logic [2:0] code;

    assign code = code_of(i_in_byte);

    always_comb begin
        push  = '0;
        n_esc = r_esc;
        n_end = r_end;
        if (r_mode == MODE_ENCODE) begin
            push.v0 = 1'b1;
            if (i_in_byte == 8'd0) begin
                push.r0 = '{data: ZERO_SUB, has: 1'b1, last: i_in_last};
            end else if (code != 3'd0) begin
                push.v1 = 1'b1;
                push.r0 = '{data: ESC_LEAD, has: 1'b1, last: 1'b0};
                push.r1 = '{data: {5'd0, code}, has: 1'b1, last: i_in_last};
            end else begin
                push.r0 = '{data: i_in_byte, has: 1'b1, last: i_in_last};
            end
        end else begin
            if (r_end) begin
                push.v0 = i_in_last;
                push.r0 = '{data: 8'd0, has: 1'b0, last: 1'b1};
            end else if (r_esc) begin
                n_esc   = 1'b0;
                push.v0 = 1'b1;
                if (i_in_byte inside {[8'd1:8'd7]}) begin
                    push.r0 = '{data: special_of(i_in_byte[2:0]), has: 1'b1, last: i_in_last};
                end else begin
                    push.r0 = '{data: ESC_LEAD, has: 1'b1, last: i_in_last};
                end
            end else if (i_in_byte == 8'd0) begin
                push.v0 = i_in_last;
                push.r0 = '{data: 8'd0, has: 1'b0, last: 1'b1};
                n_end   = 1'b1;
            end else if (i_in_byte == ZERO_SUB) begin
                push.v0 = 1'b1;
                push.r0 = '{data: 8'd0, has: 1'b1, last: i_in_last};
            end else if (i_in_byte == ESC_LEAD) begin
                push.v0 = i_in_last;
                push.r0 = '{data: 8'd0, has: 1'b0, last: 1'b1};
                n_esc   = 1'b1;
            end else begin
                push.v0 = 1'b1;
                push.r0 = '{data: i_in_byte, has: 1'b1, last: i_in_last};
            end
            if (i_in_last) begin
                n_esc = 1'b0;
                n_end = 1'b0;
            end
        end
        if (!i_accept) begin
            push  = '0;
            n_esc = r_esc;
            n_end = r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
            r_esc  <= 1'b0;
            r_end  <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
            r_esc  <= 1'b0;
            r_end  <= 1'b0;
        end else begin
            r_esc  <= n_esc;
            r_end  <= n_end;
        end
    end

    assign o_push = push;

    a_v1_needs_v0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> o_push.v0)
        else $error("second result pushed without first");
    a_v1_encode_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (r_mode == MODE_ENCODE && !o_push.r0.last))
        else $error("two results outside encode or first marked last");
    a_state_encode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ENCODE && !i_cfg_we) |=> ($stable(r_esc) && $stable(r_end)))
        else $error("decode state changed in encode mode");

endmodule

// ===== sv/bec_outq.sv =====
// bec_outq: small result queue that takes up to two results a cycle and hands out one.
// Depends on bec_pkg.
`timescale 1ns / 1ps

module bec_outq #(
    parameter int QDEPTH = bec_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bec_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output bec_pkg::t_result o_head
);
    import bec_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int SUM_W = PTR_W + 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(QDEPTH - 2);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QDEPTH);

    t_result r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W-1:0] wr_alt;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] push_n;
    logic             pop;

    // advance a pointer by 0..2 and wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [1:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(k);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[PTR_W-1:0];
    endfunction

    assign pop    = i_pop && (r_count != '0);
    assign push_n = CNT_W'(i_push.v0) + CNT_W'(i_push.v1);
    assign wr_alt = ptr_add(r_wr, 2'd1);

    always_comb begin
        n_wr    = ptr_add(r_wr, 2'(push_n));
        n_rd    = ptr_add(r_rd, {1'b0, pop});
        n_count = r_count + push_n - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_alt] <= i_push.r1;
        end
    end

    assign o_room  = (r_count <= ROOM_MAX);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> o_room)
        else $error("push without room");
    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.v0) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("count did not drop on transfer out");

endmodule

// ===== sv/byte_escape_codec.sv =====
// byte_escape_codec: top level of the byte-stuffing escape codec.
// Depends on bec_pkg, bec_map and bec_outq.
`timescale 1ns / 1ps
//
// Input channel: i_valid / o_stall carry i_in_byte and i_in_last; a transfer
// happens on a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall carry o_out_byte, o_has_byte and o_out_last.
// i_cfg_we writes i_cfg_mode (0 encode, 1 decode) and starts a fresh message;
// write it only while the block is idle.
// Each input byte is mapped in the cycle it is taken and its one or two
// results are written into a QDEPTH-entry result queue at the input
// transfer. One byte is taken every cycle while the queue holds at most
// QDEPTH-2 results, so bytes that expand to two results, which need two
// output transfers each, set the sustained rate.
// Decode bytes that give no result leave the queue untouched.
// When the receiver stalls, the head result holds and the queue fills;
// o_stall rises once fewer than two entries are free.
// Reset (i_rst_n low, synchronous) empties the queue, selects encode and
// clears the decode state.
//

module byte_escape_codec #(
    parameter int QDEPTH = bec_pkg::Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_mode,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_out_last
);
    import bec_pkg::*;

    t_push   push;
    t_result head;
    logic    room;
    logic    accept;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    bec_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_mode (i_cfg_mode),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_push     (push)
    );

    bec_outq #(
        .QDEPTH (QDEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_room  (room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_out_byte = head.data;
    assign o_has_byte = head.has;
    assign o_out_last = head.last;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for byte_escape_codec in encode and decode modes.
// Depends on bec_pkg and byte_escape_codec; directed table, then random messages.

module tb;
    import bec_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_ITEMS    = 600;
    localparam int NUM_PHASES    = 8;
    localparam int N_DIRECTED    = 26;

    localparam logic [7:0] ESCAPED_BYTES [1:7] =
        '{8'd10, 8'd13, 8'd34, 8'd39, 8'd92, 8'd254, 8'd255};

    localparam t_result NO_RES   = '{8'd0, 1'b0, 1'b0};
    localparam t_result END_MARK = '{8'd0, 1'b0, 1'b1};

    typedef struct {
        logic       wr;
        logic       mode;
        logic [7:0] data;
        logic       last;
        int         n;
        t_result    e0;
        t_result    e1;
    } t_dir_step;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_mode;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_has_byte;
    logic       o_out_last;

    logic    codec_mode;
    logic    esc_wait;
    logic    tail_drop;
    t_result expected_results [$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // n = -1: take the expectation from the predictor
    t_dir_step directed_steps [N_DIRECTED] = '{
        '{1'b0, MODE_ENCODE, 8'd0,   1'b0, 1,  '{ZERO_SUB, 1'b1, 1'b0}, NO_RES},
        '{1'b0, MODE_ENCODE, 8'd255, 1'b0, 2,  '{ESC_LEAD, 1'b1, 1'b0}, '{8'd7, 1'b1, 1'b0}},
        '{1'b0, MODE_ENCODE, 8'd254, 1'b0, 2,  '{ESC_LEAD, 1'b1, 1'b0}, '{8'd6, 1'b1, 1'b0}},
        '{1'b0, MODE_ENCODE, 8'd10,  1'b0, 2,  '{ESC_LEAD, 1'b1, 1'b0}, '{8'd1, 1'b1, 1'b0}},
        '{1'b0, MODE_ENCODE, 8'd13,  1'b0, -1, NO_RES, NO_RES},
        '{1'b0, MODE_ENCODE, 8'd34,  1'b0, -1, NO_RES, NO_RES},
        '{1'b0, MODE_ENCODE, 8'd92,  1'b1, 2,  '{ESC_LEAD, 1'b1, 1'b0}, '{8'd5, 1'b1, 1'b1}},
        '{1'b0, MODE_ENCODE, 8'd1,   1'b1, 1,  '{8'd1, 1'b1, 1'b1}, NO_RES},
        '{1'b0, MODE_ENCODE, 8'd0,   1'b1, 1,  '{ZERO_SUB, 1'b1, 1'b1}, NO_RES},
        '{1'b1, MODE_DECODE, 8'd255, 1'b0, 1,  '{8'd0, 1'b1, 1'b0}, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd3,   1'b0, 1,  '{8'd34, 1'b1, 1'b0}, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd9,   1'b0, 1,  '{ESC_LEAD, 1'b1, 1'b0}, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd0,   1'b0, 1,  '{ESC_LEAD, 1'b1, 1'b0}, NO_RES},
        '{1'b0, MODE_DECODE, 8'd65,  1'b1, -1, NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b1, 1,  END_MARK, NO_RES},
        '{1'b0, MODE_DECODE, 8'd0,   1'b1, 1,  END_MARK, NO_RES},
        '{1'b0, MODE_DECODE, 8'd0,   1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd255, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd128, 1'b1, 1,  END_MARK, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b1, MODE_DECODE, 8'd7,   1'b1, 1,  '{8'd7, 1'b1, 1'b1}, NO_RES},
        '{1'b0, MODE_DECODE, 8'd254, 1'b0, 0,  NO_RES, NO_RES},
        '{1'b0, MODE_DECODE, 8'd7,   1'b1, 1,  '{8'd255, 1'b1, 1'b1}, NO_RES}
    };

    byte_escape_codec dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_mode (i_cfg_mode),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_has_byte (o_has_byte),
        .o_out_last (o_out_last)
    );

    function automatic logic [2:0] escape_code_for(input logic [7:0] b);
        logic [2:0] code;
        code = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (ESCAPED_BYTES[k] == b) begin
                code = 3'(k);
            end
        end
        return code;
    endfunction

    function automatic void predict_codec(input logic [7:0] b, input logic l,
                                          output int cnt, output t_result r0,
                                          output t_result r1);
        logic [2:0] code;
        cnt = 0;
        r0 = NO_RES;
        r1 = NO_RES;
        code = escape_code_for(b);
        if (codec_mode == MODE_ENCODE) begin
            if (b == 8'd0) begin
                r0 = '{ZERO_SUB, 1'b1, l};
                cnt = 1;
            end else if (code != 3'd0) begin
                r0 = '{ESC_LEAD, 1'b1, 1'b0};
                r1 = '{{5'd0, code}, 1'b1, l};
                cnt = 2;
            end else begin
                r0 = '{b, 1'b1, l};
                cnt = 1;
            end
        end else begin
            if (tail_drop) begin
                if (l) begin
                    r0 = END_MARK;
                    cnt = 1;
                end
            end else if (esc_wait) begin
                esc_wait = 1'b0;
                if (b >= 8'd1 && b <= 8'd7) begin
                    r0 = '{ESCAPED_BYTES[b[2:0]], 1'b1, l};
                end else begin
                    r0 = '{ESC_LEAD, 1'b1, l};
                end
                cnt = 1;
            end else if (b == 8'd0) begin
                if (l) begin
                    r0 = END_MARK;
                    cnt = 1;
                end else begin
                    tail_drop = 1'b1;
                end
            end else if (b == ZERO_SUB) begin
                r0 = '{8'd0, 1'b1, l};
                cnt = 1;
            end else if (b == ESC_LEAD) begin
                if (l) begin
                    r0 = END_MARK;
                    cnt = 1;
                end else begin
                    esc_wait = 1'b1;
                end
            end else begin
                r0 = '{b, 1'b1, l};
                cnt = 1;
            end
            if (l) begin
                esc_wait = 1'b0;
                tail_drop = 1'b0;
            end
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0: return ESCAPED_BYTES[$urandom_range(1, 7)];
            1: return $urandom_range(1) ? 8'd0 : 8'($urandom_range(1, 7));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // call right after a falling edge; returns just after a falling edge, once the byte has been taken
    task automatic send_item(input logic [7:0] b, input logic l, input int n_typed,
                             input t_result t0, input t_result t1, output int cnt);
        t_result r0, r1;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_codec(b, l, cnt, r0, r1);
        if (n_typed >= 0) begin
            cnt = n_typed;
            r0 = t0;
            r1 = t1;
        end
        if (cnt > 0) expected_results.push_back(r0);
        if (cnt > 1) expected_results.push_back(r1);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_mode <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        codec_mode = m;
        esc_wait   = 1'b0;
        tail_drop  = 1'b0;
    endtask

    task automatic send_message(inout int counted);
        logic [7:0] msg [$];
        logic [7:0] raw;
        logic [2:0] code;
        int         len, kind, cnt;
        len = $urandom_range(1, 8);
        kind = $urandom_range(9);
        if (codec_mode == MODE_ENCODE || kind >= 8) begin
            repeat (len) msg.push_back(pick_byte());
            // broken decode message: dangling escape or escape with a random code byte
            if (codec_mode == MODE_DECODE) begin
                msg.push_back(ESC_LEAD);
                if ($urandom_range(1)) msg.push_back(8'($urandom_range(255)));
            end
        end else if (kind >= 6) begin
            repeat (len) msg.push_back(8'($urandom_range(255)));
        end else begin
            repeat (len) begin
                raw = pick_byte();
                code = escape_code_for(raw);
                if (raw == 8'd0) begin
                    msg.push_back(ZERO_SUB);
                end else if (code != 3'd0) begin
                    msg.push_back(ESC_LEAD);
                    msg.push_back({5'd0, code});
                end else begin
                    msg.push_back(raw);
                end
            end
            if (kind >= 4) begin
                msg.push_back(8'd0);
                repeat ($urandom_range(3)) msg.push_back(pick_byte());
            end
        end
        foreach (msg[k]) begin
            send_item(msg[k], k == msg.size() - 1, -1, NO_RES, NO_RES, cnt);
            if (cnt > 0) counted++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_byte, o_has_byte, o_out_last};
            if (expected_results.size() == 0) begin
                $error("unexpected transfer: out_byte %0d has_byte %0b out_last %0b",
                       got.data, got.has, got.last);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.data !== want.data) begin
                    $error("out_byte: expected %0d, got %0d", want.data, got.data);
                    errors++;
                end
                if (got.has !== want.has) begin
                    $error("has_byte: expected %0b, got %0b", want.has, got.has);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int cnt, counted;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_mode = MODE_ENCODE;
        i_valid    = 1'b0;
        i_in_byte  = 8'd0;
        i_in_last  = 1'b0;
        codec_mode = MODE_ENCODE;
        esc_wait   = 1'b0;
        tail_drop  = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].wr) write_mode(directed_steps[k].mode);
            send_item(directed_steps[k].data, directed_steps[k].last, directed_steps[k].n,
                      directed_steps[k].e0, directed_steps[k].e1, cnt);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_mode(phase % 2 ? MODE_DECODE : MODE_ENCODE);
            case (phase / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            counted = 0;
            while (counted < RAND_ITEMS / NUM_PHASES) send_message(counted);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
